// File: src/dlfc_pkg.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker package
// Shared constants, transaction types and byte classification helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package dlfc_pkg;

    // Longest record in bytes before it is forced closed
    localparam int RECORD_MAX = 4096;
    // Record byte counter width, able to hold RECORD_MAX itself
    localparam int CNT_W      = $clog2(RECORD_MAX + 1);

    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 13;
    localparam int CHUNK_W    = 16;
    localparam int LIMIT_W    = 32;
    localparam int TOTAL_W    = LIMIT_W + 1;
    localparam int SAT_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic [LEN_W-1:0]   LEN_SAT           = {LEN_W{1'b1}};
    localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RESET = 32'd100000000;

    // Byte codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC    = 8'h43;
    localparam logic [CHAR_W-1:0] CH_UG    = 8'h47;
    localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC    = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LG    = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h74;

    // Input transaction
    typedef struct packed {
        logic [CHAR_W-1:0] in_byte;
        logic              file_end;
    } item_t;

    // Per-byte record verdict from the record tracker
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              is_content;
        logic              record_end;
        logic              record_kept;
        logic [CNT_W-1:0]  length;
    } rec_info_t;

    // Chunk verdict from the chunk accountant
    typedef struct packed {
        logic               new_chunk;
        logic [CHUNK_W-1:0] chunk_number;
    } chunk_info_t;

    // Result transaction
    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               is_content;
        logic               record_end;
        logic               record_kept;
        logic [LEN_W-1:0]   record_length;
        logic               new_chunk;
        logic [CHUNK_W-1:0] chunk_number;
    } result_t;

    function automatic logic is_lower_base(input logic [CHAR_W-1:0] b);
        return (b == CH_LA) || (b == CH_LC) || (b == CH_LG) || (b == CH_LT);
    endfunction

    function automatic logic is_base(input logic [CHAR_W-1:0] b);
        return is_lower_base(b) ||
               (b == CH_UA) || (b == CH_UC) || (b == CH_UG) || (b == CH_UT);
    endfunction

    function automatic logic [CHAR_W-1:0] to_upper_base(input logic [CHAR_W-1:0] b);
        return is_lower_base(b) ? (b - CASE_OFS) : b;
    endfunction

    function automatic logic is_term(input logic [CHAR_W-1:0] b);
        return (b == CH_LF) || (b == CH_SPACE) || (b == CH_NUL);
    endfunction

    // Clamp a record length to the output field
    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] len);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(len);
        if (wide > SAT_W'(LEN_SAT)) begin
            return LEN_SAT;
        end
        return LEN_W'(wide);
    endfunction

endpackage

`default_nettype wire

// File: src/dlfc_in_reg.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker input register
// Captures one byte transaction and holds it until the pipe advances.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfc_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire dlfc_pkg::item_t s_item,
    input  wire logic          advance,
    output logic               item_valid,
    output dlfc_pkg::item_t    item
);

    logic            valid_reg;
    logic            valid_next;
    dlfc_pkg::item_t item_reg;

    // Accept when empty or when the held transaction moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: src/dlfc_record.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker record tracker
// Classifies each byte, counts content and decides record end and keep.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfc_record (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire dlfc_pkg::item_t item,
    output dlfc_pkg::rec_info_t  info
);

    logic [dlfc_pkg::CNT_W-1:0] record_count_reg;
    logic [dlfc_pkg::CNT_W-1:0] record_count_next;
    logic [dlfc_pkg::CNT_W-1:0] content_length_reg;
    logic [dlfc_pkg::CNT_W-1:0] content_length_next;
    logic                       terminator_seen_reg;
    logic                       terminator_seen_next;
    logic                       record_bad_reg;
    logic                       record_bad_next;

    logic                       term;
    logic                       content;
    logic                       bad;
    logic [dlfc_pkg::CNT_W-1:0] count_inc;
    logic [dlfc_pkg::CNT_W-1:0] length_inc;
    logic                       rec_end;

    // Classify the byte against the record so far
    always_comb begin
        term       = dlfc_pkg::is_term(item.in_byte);
        content    = !terminator_seen_reg && !term;
        bad        = record_bad_reg || (content && !dlfc_pkg::is_base(item.in_byte));
        count_inc  = record_count_reg + dlfc_pkg::CNT_W'(1);
        length_inc = content ? (content_length_reg + dlfc_pkg::CNT_W'(1))
                             : content_length_reg;
        rec_end    = (item.in_byte == dlfc_pkg::CH_LF) || item.file_end ||
                     (count_inc >= dlfc_pkg::CNT_W'(dlfc_pkg::RECORD_MAX));
    end

    // Advance record state, clear it at record end
    always_comb begin
        record_count_next    = record_count_reg;
        content_length_next  = content_length_reg;
        terminator_seen_next = terminator_seen_reg;
        record_bad_next      = record_bad_reg;
        if (advance) begin
            if (rec_end) begin
                record_count_next    = '0;
                content_length_next  = '0;
                terminator_seen_next = 1'b0;
                record_bad_next      = 1'b0;
            end else begin
                record_count_next    = count_inc;
                content_length_next  = length_inc;
                terminator_seen_next = terminator_seen_reg || term;
                record_bad_next      = bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_count_reg    <= '0;
            content_length_reg  <= '0;
            terminator_seen_reg <= 1'b0;
            record_bad_reg      <= 1'b0;
        end else begin
            record_count_reg    <= record_count_next;
            content_length_reg  <= content_length_next;
            terminator_seen_reg <= terminator_seen_next;
            record_bad_reg      <= record_bad_next;
        end
    end

    // Verdict for this byte
    always_comb begin
        info.out_char    = dlfc_pkg::to_upper_base(item.in_byte);
        info.is_content  = content;
        info.record_end  = rec_end;
        info.record_kept = rec_end && !bad;
        info.length      = rec_end ? length_inc : '0;
    end

endmodule

`default_nettype wire

// File: src/dlfc_chunk.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker chunk accountant
// Adds kept record lengths into the chunk total and numbers the chunks.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfc_chunk (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dlfc_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  wire logic                          advance,
    input  wire logic                          file_end,
    input  wire dlfc_pkg::rec_info_t           info,
    output dlfc_pkg::chunk_info_t              chunk
);

    logic [dlfc_pkg::LIMIT_W-1:0] chunk_limit_reg;
    logic [dlfc_pkg::TOTAL_W-1:0] chunk_total_reg;
    logic [dlfc_pkg::TOTAL_W-1:0] chunk_total_next;
    logic [dlfc_pkg::CHUNK_W-1:0] current_chunk_reg;
    logic [dlfc_pkg::CHUNK_W-1:0] current_chunk_next;
    logic                         file_starting_reg;
    logic                         file_starting_next;

    logic [dlfc_pkg::CHUNK_W-1:0] chunk_open;
    logic [dlfc_pkg::TOTAL_W-1:0] total_open;
    logic [dlfc_pkg::TOTAL_W-1:0] sum;
    logic                         overflow;
    logic [dlfc_pkg::TOTAL_W-1:0] total_upd;
    logic [dlfc_pkg::CHUNK_W-1:0] chunk_upd;

    // Open a chunk on a file's first byte, then add a kept record
    always_comb begin
        chunk_open = file_starting_reg ? (current_chunk_reg + dlfc_pkg::CHUNK_W'(1))
                                       : current_chunk_reg;
        total_open = file_starting_reg ? '0 : chunk_total_reg;
        sum        = total_open + dlfc_pkg::TOTAL_W'(info.length);
        overflow   = info.record_kept &&
                     (sum > dlfc_pkg::TOTAL_W'(chunk_limit_reg));
        chunk_upd  = overflow ? (chunk_open + dlfc_pkg::CHUNK_W'(1)) : chunk_open;
        if (!info.record_kept) begin
            total_upd = total_open;
        end else if (overflow) begin
            total_upd = dlfc_pkg::TOTAL_W'(info.length);
        end else begin
            total_upd = sum;
        end
    end

    always_comb begin
        chunk_total_next   = chunk_total_reg;
        current_chunk_next = current_chunk_reg;
        file_starting_next = file_starting_reg;
        if (advance) begin
            chunk_total_next   = total_upd;
            current_chunk_next = chunk_upd;
            file_starting_next = file_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_limit_reg   <= dlfc_pkg::CHUNK_LIMIT_RESET;
            chunk_total_reg   <= '0;
            current_chunk_reg <= '0;
            file_starting_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                chunk_limit_reg <= cfg_wr_data;
            end
            chunk_total_reg   <= chunk_total_next;
            current_chunk_reg <= current_chunk_next;
            file_starting_reg <= file_starting_next;
        end
    end

    // The chunk in use is one behind the count of chunks opened
    assign chunk.new_chunk    = overflow;
    assign chunk.chunk_number = chunk_upd - dlfc_pkg::CHUNK_W'(1);

endmodule

`default_nettype wire

// File: src/dlfc_out_reg.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker output register
// Holds one result transaction until downstream takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfc_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire dlfc_pkg::result_t result,
    output logic                   advance,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dlfc_pkg::result_t      m_result
);

    logic              valid_reg;
    logic              valid_next;
    dlfc_pkg::result_t result_reg;

    // Move a transaction in when the slot is free or being emptied
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// File: src/dna_line_filter_chunker_core.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker core
// Streams DNA text bytes, marks record content, keeps or drops records and
// assigns kept records to size-limited chunks.
// ---------------------------------------------------------------------------
//
//  Channel  Ports              Transaction
//  -------  -----------------  ------------------------------------------
//  input    s_valid / s_ready  one source byte and its file_end flag
//  result   m_valid / m_ready  one verdict per byte, chunk at record end
//  config   cfg_wr_en          chunk_limit, written at once
//
//  A byte is captured in the input register, classified and accounted in
//  one pass of logic, and lands in the output register: its result is
//  offered on m_valid from there. One byte per cycle is sustained while
//  the receiver takes results. The record and chunk state registers close
//  the loop from one byte to the next in that single pass.
//  Reset leaves both registers empty and the first file on chunk zero.
//  A stalled result holds the output register; the input register takes
//  one more byte, then s_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module dna_line_filter_chunker_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dlfc_pkg::LIMIT_W-1:0]      cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [dlfc_pkg::CHAR_W-1:0]       s_in_byte,
    input  wire logic                              s_file_end,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [dlfc_pkg::CHAR_W-1:0]            m_out_char,
    output logic                                   m_is_content,
    output logic                                   m_record_end,
    output logic                                   m_record_kept,
    output logic [dlfc_pkg::LEN_W-1:0]             m_record_length,
    output logic                                   m_new_chunk,
    output logic [dlfc_pkg::CHUNK_W-1:0]           m_chunk_number
);

    dlfc_pkg::item_t       s_item;
    dlfc_pkg::item_t       item;
    logic                  item_valid;
    logic                  advance;
    dlfc_pkg::rec_info_t   info;
    dlfc_pkg::chunk_info_t chunk;
    dlfc_pkg::result_t     result;
    dlfc_pkg::result_t     m_result;

    assign s_item.in_byte  = s_in_byte;
    assign s_item.file_end = s_file_end;

    dlfc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dlfc_record u_record (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .info    (info)
    );

    dlfc_chunk u_chunk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .file_end    (item.file_end),
        .info        (info),
        .chunk       (chunk)
    );

    // Assemble the result transaction
    always_comb begin
        result.out_char      = info.out_char;
        result.is_content    = info.is_content;
        result.record_end    = info.record_end;
        result.record_kept   = info.record_kept;
        result.record_length = dlfc_pkg::sat_len(info.length);
        result.new_chunk     = chunk.new_chunk;
        result.chunk_number  = chunk.chunk_number;
    end

    dlfc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_out_char      = m_result.out_char;
    assign m_is_content    = m_result.is_content;
    assign m_record_end    = m_result.record_end;
    assign m_record_kept   = m_result.record_kept;
    assign m_record_length = m_result.record_length;
    assign m_new_chunk     = m_result.new_chunk;
    assign m_chunk_number  = m_result.chunk_number;

endmodule

`default_nettype wire

// File: src/dlfc_checker.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker checker
// Port-level assertions on the result channel, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfc_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [dlfc_pkg::CHAR_W-1:0]       m_out_char,
    input  wire logic                              m_is_content,
    input  wire logic                              m_record_end,
    input  wire logic                              m_record_kept,
    input  wire logic [dlfc_pkg::LEN_W-1:0]        m_record_length,
    input  wire logic                              m_new_chunk,
    input  wire logic [dlfc_pkg::CHUNK_W-1:0]      m_chunk_number
);

    // Hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) &&
            $stable(m_record_end) && $stable(m_chunk_number))
        else $error("result changed while stalled");

    // Record fields stay zero away from a record end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_record_end |->
            !m_record_kept && !m_new_chunk && (m_record_length == '0))
        else $error("record fields set without record end");

    // Only a kept record can open a chunk
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_chunk |-> m_record_end && m_record_kept)
        else $error("new chunk without kept record");

    // A terminator byte is never content
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_content |->
            (m_out_char != dlfc_pkg::CH_LF) && (m_out_char != dlfc_pkg::CH_SPACE) &&
            (m_out_char != dlfc_pkg::CH_NUL))
        else $error("terminator flagged as content");

endmodule

bind dna_line_filter_chunker_core dlfc_checker u_dlfc_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// DNA line filter chunker testbench
// Streams byte sequences through the core, predicts the verdict of every byte
// and the chunk of every kept record, and checks results in arrival order
// under random idling, long receiver stalls and chunk limit changes.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

    // Cycle limit with a wide margin over the slowest correct run
    localparam int CYCLE_LIMIT = 300_000;
    localparam int LATENCY_PAD = 8;
    localparam int HOLD_CYCLES = 400;

    localparam logic [dlfc_pkg::CHAR_W-1:0]  CH_UN     = 8'h4E;
    localparam logic [dlfc_pkg::CHAR_W-1:0]  CH_LX     = 8'h78;
    localparam logic [dlfc_pkg::CHAR_W-1:0]  BYTE_MAX  = 8'hFF;
    localparam logic [dlfc_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [dlfc_pkg::LIMIT_W-1:0]     cfg_wr_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [dlfc_pkg::CHAR_W-1:0]      s_in_byte;
    logic                             s_file_end;
    logic                             m_valid;
    logic                             m_ready;
    logic [dlfc_pkg::CHAR_W-1:0]      m_out_char;
    logic                             m_is_content;
    logic                             m_record_end;
    logic                             m_record_kept;
    logic [dlfc_pkg::LEN_W-1:0]       m_record_length;
    logic                             m_new_chunk;
    logic [dlfc_pkg::CHUNK_W-1:0]     m_chunk_number;

    // Predicted state of the record tracker and chunk accountant
    logic [dlfc_pkg::LIMIT_W-1:0]     limit_now;
    logic [dlfc_pkg::TOTAL_W-1:0]     fill_total;
    int                               rec_bytes;
    int                               content_len;
    logic                             past_term;
    logic                             rec_bad;
    logic                             file_open_pending;
    logic [dlfc_pkg::CHUNK_W-1:0]     chunks_opened;

    dlfc_pkg::result_t                verdict_q[$];

    logic                             send_idle_en;
    logic                             recv_idle_en;
    int                               hold_cycles     = 0;
    int                               bytes_sent      = 0;
    int                               results_checked = 0;
    int                               mismatch_count  = 0;
    int                               cycle_count     = 0;

    dna_line_filter_chunker_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_file_end      (s_file_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_is_content    (m_is_content),
        .m_record_end    (m_record_end),
        .m_record_kept   (m_record_kept),
        .m_record_length (m_record_length),
        .m_new_chunk     (m_new_chunk),
        .m_chunk_number  (m_chunk_number)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("dna_line_filter_chunker_core test failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Verdict predictor
    // -----------------------------------------------------------------------
    function automatic logic [dlfc_pkg::CHAR_W-1:0] fold_case(
        input logic [dlfc_pkg::CHAR_W-1:0] b);
        case (b)
            dlfc_pkg::CH_LA: return dlfc_pkg::CH_UA;
            dlfc_pkg::CH_LC: return dlfc_pkg::CH_UC;
            dlfc_pkg::CH_LG: return dlfc_pkg::CH_UG;
            dlfc_pkg::CH_LT: return dlfc_pkg::CH_UT;
            default:         return b;
        endcase
    endfunction

    function automatic logic is_nucleotide(input logic [dlfc_pkg::CHAR_W-1:0] b);
        logic [dlfc_pkg::CHAR_W-1:0] u;
        u = fold_case(b);
        return (u == dlfc_pkg::CH_UA) || (u == dlfc_pkg::CH_UC) ||
               (u == dlfc_pkg::CH_UG) || (u == dlfc_pkg::CH_UT);
    endfunction

    function automatic dlfc_pkg::result_t predict_verdict(
        input logic [dlfc_pkg::CHAR_W-1:0] b, input logic fe);
        dlfc_pkg::result_t            r;
        logic                         term;
        logic                         content;
        logic [dlfc_pkg::TOTAL_W-1:0] sum;
        r = '0;
        // First byte of a file opens a chunk and clears the fill
        if (file_open_pending) begin
            chunks_opened     = chunks_opened + 1'b1;
            fill_total        = '0;
            file_open_pending = 1'b0;
        end
        term    = (b == dlfc_pkg::CH_LF) || (b == dlfc_pkg::CH_SPACE) ||
                  (b == dlfc_pkg::CH_NUL);
        content = !past_term && !term;
        if (content) begin
            if (!is_nucleotide(b)) begin
                rec_bad = 1'b1;
            end
            content_len++;
        end
        if (term) begin
            past_term = 1'b1;
        end
        rec_bytes++;
        r.out_char   = fold_case(b);
        r.is_content = content;
        // Close the record on line feed, file end or the size cap
        if ((b == dlfc_pkg::CH_LF) || fe || (rec_bytes >= dlfc_pkg::RECORD_MAX)) begin
            r.record_end    = 1'b1;
            r.record_kept   = !rec_bad;
            r.record_length = (content_len > int'(dlfc_pkg::LEN_SAT)) ?
                              dlfc_pkg::LEN_SAT : dlfc_pkg::LEN_W'(content_len);
            if (!rec_bad) begin
                sum = fill_total + dlfc_pkg::TOTAL_W'(content_len);
                if (sum > dlfc_pkg::TOTAL_W'(limit_now)) begin
                    r.new_chunk   = 1'b1;
                    chunks_opened = chunks_opened + 1'b1;
                    fill_total    = dlfc_pkg::TOTAL_W'(content_len);
                end else begin
                    fill_total = sum;
                end
            end
            rec_bytes   = 0;
            content_len = 0;
            past_term   = 1'b0;
            rec_bad     = 1'b0;
            if (fe) begin
                file_open_pending = 1'b1;
            end
        end
        r.chunk_number = chunks_opened - 1'b1;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        dlfc_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("transaction with none pending", 32'(m_out_char), '0);
            end else begin
                want = verdict_q.pop_front();
                if (m_out_char != want.out_char)
                    report_mismatch("out_char", 32'(m_out_char), 32'(want.out_char));
                if (m_is_content != want.is_content)
                    report_mismatch("is_content", 32'(m_is_content),
                                    32'(want.is_content));
                if (m_record_end != want.record_end)
                    report_mismatch("record_end", 32'(m_record_end),
                                    32'(want.record_end));
                if (m_record_kept != want.record_kept)
                    report_mismatch("record_kept", 32'(m_record_kept),
                                    32'(want.record_kept));
                if (m_record_length != want.record_length)
                    report_mismatch("record_length", 32'(m_record_length),
                                    32'(want.record_length));
                if (m_new_chunk != want.new_chunk)
                    report_mismatch("new_chunk", 32'(m_new_chunk), 32'(want.new_chunk));
                if (m_chunk_number != want.chunk_number)
                    report_mismatch("chunk_number", 32'(m_chunk_number),
                                    32'(want.chunk_number));
            end
            results_checked++;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stall bursts, plus long hold-offs on request
    // -----------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end else if (stall_left == 0 && recv_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sender helpers
    // -----------------------------------------------------------------------
    // Offer one byte, hold it until accepted, then record its verdict
    task automatic send_byte(input logic [dlfc_pkg::CHAR_W-1:0] b, input logic fe);
        int gap;
        if (send_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_byte  <= b;
        s_file_end <= fe;
        do @(posedge aclk); while (!s_ready);
        verdict_q.push_back(predict_verdict(b, fe));
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic pause_sender();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop sending and wait until every verdict is back and the core is quiet
    task automatic wait_drained();
        pause_sender();
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (LATENCY_PAD) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [dlfc_pkg::LIMIT_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_now    = value;
    endtask

    function automatic logic [dlfc_pkg::CHAR_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return dlfc_pkg::CH_UA;
            1:       return dlfc_pkg::CH_UC;
            2:       return dlfc_pkg::CH_UG;
            3:       return dlfc_pkg::CH_UT;
            4:       return dlfc_pkg::CH_LA;
            5:       return dlfc_pkg::CH_LC;
            6:       return dlfc_pkg::CH_LG;
            default: return dlfc_pkg::CH_LT;
        endcase
    endfunction

    // Any byte that spoils a record without ending its content
    function automatic logic [dlfc_pkg::CHAR_W-1:0] pick_stray();
        logic [dlfc_pkg::CHAR_W-1:0] b;
        if ($urandom_range(0, 1) == 0) begin
            return CH_UN;
        end
        do begin
            b = dlfc_pkg::CHAR_W'($urandom_range(0, 255));
        end while (is_nucleotide(b) || b == dlfc_pkg::CH_LF || b == dlfc_pkg::CH_SPACE ||
                   b == dlfc_pkg::CH_NUL);
        return b;
    endfunction

    function automatic logic [dlfc_pkg::CHAR_W-1:0] pick_non_lf();
        logic [dlfc_pkg::CHAR_W-1:0] b;
        do begin
            b = dlfc_pkg::CHAR_W'($urandom_range(0, 255));
        end while (b == dlfc_pkg::CH_LF);
        return b;
    endfunction

    task automatic send_bases(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(pick_base(), 1'b0);
        end
    endtask

    // Mostly well-formed records with random content, some raw noise
    task automatic send_random_record();
        int   n;
        int   bad_at;
        int   junk;
        logic closes_file;
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                send_byte(dlfc_pkg::CHAR_W'($urandom_range(0, 255)),
                          $urandom_range(0, 9) == 0);
            end
        end else begin
            n           = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300)
                                                       : $urandom_range(0, 24);
            bad_at      = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : -1;
            junk        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1;
            closes_file = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < n; i++) begin
                send_byte((i == bad_at) ? pick_stray() : pick_base(), 1'b0);
            end
            // Terminator other than line feed, then unchecked trailing bytes
            if (junk >= 0) begin
                send_byte(($urandom_range(0, 1) == 0) ? dlfc_pkg::CH_SPACE
                                                      : dlfc_pkg::CH_NUL, 1'b0);
                for (int i = 0; i < junk; i++) begin
                    send_byte(pick_non_lf(), 1'b0);
                end
            end
            if (closes_file && $urandom_range(0, 1) == 0) begin
                send_byte(pick_base(), 1'b1);
            end else begin
                send_byte(dlfc_pkg::CH_LF, closes_file);
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_directed();
        // Lower case bases fold to upper case and the record is kept
        send_byte(dlfc_pkg::CH_LA, 1'b0);
        send_byte(dlfc_pkg::CH_LC, 1'b0);
        send_byte(dlfc_pkg::CH_LG, 1'b0);
        send_byte(dlfc_pkg::CH_LT, 1'b0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // Space ends the content; bytes after it pass unchecked
        send_byte(dlfc_pkg::CH_UA, 1'b0);
        send_byte(dlfc_pkg::CH_UC, 1'b0);
        send_byte(dlfc_pkg::CH_SPACE, 1'b0);
        send_byte(dlfc_pkg::CH_UG, 1'b0);
        send_byte(CH_LX, 1'b0);
        send_byte(CH_UN, 1'b0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // Empty record
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // NUL terminator with the top byte value behind it
        send_byte(dlfc_pkg::CH_NUL, 1'b0);
        send_byte(BYTE_MAX, 1'b0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // Non-base content drops the record
        send_byte(dlfc_pkg::CH_UA, 1'b0);
        send_byte(CH_UN, 1'b0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // File ends on a dropped record
        send_byte(BYTE_MAX, 1'b0);
        send_byte(dlfc_pkg::CH_LG, 1'b1);
        // New file opens a chunk; one-byte record closed by file end
        send_byte(dlfc_pkg::CH_UT, 1'b1);
    endtask

    task automatic test_chunk_limits();
        set_limit(dlfc_pkg::LIMIT_W'(3));
        send_bases(3);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // Overflow opens a chunk
        send_bases(1);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        send_bases(2);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        // File end closes a record that overflows the full chunk
        send_byte(dlfc_pkg::CH_UT, 1'b1);
        // First record of a file beyond the limit opens a further chunk
        send_bases(4);
        send_byte(dlfc_pkg::CH_LA, 1'b1);
        set_limit('0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        send_bases(1);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        set_limit(LIMIT_MAX);
        send_bases(6);
        send_byte(dlfc_pkg::CH_LF, 1'b1);
        send_bases(2);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
    endtask

    task automatic test_backpressure();
        set_limit(dlfc_pkg::LIMIT_W'(25));
        hold_cycles = HOLD_CYCLES;
        // Keep offering while the receiver holds off
        send_bases(40);
        send_byte(dlfc_pkg::CH_LF, 1'b0);
        repeat (6) send_random_record();
    endtask

    task automatic test_drain_pause();
        repeat (4) send_random_record();
        wait_drained();
        repeat (4) send_random_record();
    endtask

    task automatic test_random();
        int target;
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       set_limit('0);
                1:       set_limit(LIMIT_MAX);
                2:       set_limit(dlfc_pkg::LIMIT_W'($urandom_range(1, 40)));
                3:       set_limit(dlfc_pkg::LIMIT_W'($urandom()));
                4:       set_limit(dlfc_pkg::LIMIT_W'($urandom_range(40, 200)));
                default: set_limit(dlfc_pkg::CHUNK_LIMIT_RESET);
            endcase
            // Every other segment runs without idling on the sender
            send_idle_en = (seg % 2 == 0);
            target = bytes_sent + 150;
            while (bytes_sent < target) send_random_record();
        end
        send_idle_en = 1'b1;
    endtask

    task automatic test_full_rate();
        int target;
        set_limit(dlfc_pkg::LIMIT_W'($urandom_range(20, 120)));
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        target = bytes_sent + 250;
        while (bytes_sent < target) send_random_record();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_in_byte    = '0;
        s_file_end   = 1'b0;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        limit_now         = dlfc_pkg::CHUNK_LIMIT_RESET;
        fill_total        = '0;
        rec_bytes         = 0;
        content_len       = 0;
        past_term         = 1'b0;
        rec_bad           = 1'b0;
        file_open_pending = 1'b1;
        chunks_opened     = '0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_chunk_limits();
        test_backpressure();
        test_drain_pause();
        test_random();
        test_full_rate();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("dna_line_filter_chunker_core test passed");
        end else begin
            $display("dna_line_filter_chunker_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: dna_line_filter_chunker_core.f
src/dlfc_pkg.sv
src/dlfc_in_reg.sv
src/dlfc_record.sv
src/dlfc_chunk.sv
src/dlfc_out_reg.sv
src/dna_line_filter_chunker_core.sv
src/dlfc_checker.sv
verif/testbench.sv
